@@ hw/rtl/rotation_matrix_to_quaternion_core_assert.svh @@
// ----------------------------------------------------------------------------
// rotation matrix to quaternion assertion macros
// concurrent checks sampled on clk, quiet while rst is high
// ----------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_TO_QUATERNION_CORE_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_CORE_ASSERT_SVH

// same-cycle implication
`define RMQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rmq check failed");

// next-cycle implication
`define RMQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rmq check failed");

`endif

@@ hw/rtl/rmq_pkg.sv @@
// ----------------------------------------------------------------------------
// rmq_pkg
// shared types and constants of the rotation matrix to quaternion core
// ----------------------------------------------------------------------------
`default_nettype none

package rmq_pkg;

  localparam int FW        = 18;
  localparam int ONE       = 65536;
  localparam int SQ_STEPS  = 18;
  localparam int DIV_STEPS = 17;
  localparam int RADW      = 35;
  localparam int MAGW      = 19;
  localparam int PW        = 36;

  typedef enum logic [1:0] {
    BR_W,
    BR_X,
    BR_Y,
    BR_Z
  } br_t;

  typedef struct packed {
    br_t                       br;
    logic [2:0]                neg;
    logic [2:0][MAGW-1:0]      mag;
  } side_t;

endpackage

`default_nettype wire

@@ hw/rtl/rotation_matrix_to_quaternion_core.sv @@
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_core
// 3x3 rotation matrix to unit quaternion, Shepperd branch choice, Q1.16
// ----------------------------------------------------------------------------
// input channel: in_valid / in_stall with the nine matrix entries m00..m22
// output channel: out_valid / out_stall with qw, qx, qy, qz
// a word is taken when valid is high and stall is low
// the pipe is one decode stage, 18 square root stages (one root
// bit each), one divider prep stage, 17 divide stages (one quotient bit
// each) and the output register
// throughput is one word per cycle unless stalled; every stage advances
// together, and when the output word is held by out_stall the whole pipe
// freezes and in_stall goes high, nothing is dropped or repeated
// a free output register lets the pipe advance in the same cycle the
// receiver takes the held word
// rst is synchronous: all valid bits clear, no word in flight survives
// each output is saturated to plus or minus one
// ----------------------------------------------------------------------------
`default_nettype none

`include "rotation_matrix_to_quaternion_core_assert.svh"

module rotation_matrix_to_quaternion_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [rmq_pkg::FW-1:0]     m00,
  input  wire logic signed [rmq_pkg::FW-1:0]     m01,
  input  wire logic signed [rmq_pkg::FW-1:0]     m02,
  input  wire logic signed [rmq_pkg::FW-1:0]     m10,
  input  wire logic signed [rmq_pkg::FW-1:0]     m11,
  input  wire logic signed [rmq_pkg::FW-1:0]     m12,
  input  wire logic signed [rmq_pkg::FW-1:0]     m20,
  input  wire logic signed [rmq_pkg::FW-1:0]     m21,
  input  wire logic signed [rmq_pkg::FW-1:0]     m22,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [rmq_pkg::FW-1:0]          qw,
  output logic signed [rmq_pkg::FW-1:0]          qx,
  output logic signed [rmq_pkg::FW-1:0]          qy,
  output logic signed [rmq_pkg::FW-1:0]          qz
);

  localparam int MW = rmq_pkg::MAGW;

  logic en;

  logic                        dec_valid;
  logic [rmq_pkg::RADW-1:0]    dec_rad;
  rmq_pkg::side_t              dec_side;

  logic [rmq_pkg::RADW-1:0]    rad_next;
  rmq_pkg::side_t              side_next;

  logic                        sq_valid;
  logic [rmq_pkg::FW-1:0]      sq_root;
  rmq_pkg::side_t              sq_side;

  logic                        dv_valid;
  rmq_pkg::br_t                dv_br;
  logic [rmq_pkg::FW-1:0]      dv_diag;
  logic [2:0][rmq_pkg::FW-1:0] dv_lane;

  logic [3:0][rmq_pkg::FW-1:0] q_next;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // decode: trace, branch, radicand and numerators
  always_comb begin
    logic signed [19:0]   tr;
    logic signed [21:0]   t;
    logic signed [MW-1:0] da, db, dc, sa, sb, sc;
    logic signed [MW-1:0] num [3];
    rmq_pkg::br_t         b;
    tr = 20'(m00) + 20'(m11) + 20'(m22);
    da = 19'(m21) - 19'(m12);
    db = 19'(m02) - 19'(m20);
    dc = 19'(m10) - 19'(m01);
    sa = 19'(m01) + 19'(m10);
    sb = 19'(m02) + 19'(m20);
    sc = 19'(m12) + 19'(m21);
    if (tr > 20'sd0) begin
      b = rmq_pkg::BR_W;
      t = 22'(rmq_pkg::ONE) + 22'(tr);
    end else if (m00 > m11 && m00 > m22) begin
      b = rmq_pkg::BR_X;
      t = 22'(rmq_pkg::ONE) + 22'(m00) + 22'(m00) - 22'(tr);
    end else if (m11 > m22) begin
      b = rmq_pkg::BR_Y;
      t = 22'(rmq_pkg::ONE) + 22'(m11) + 22'(m11) - 22'(tr);
    end else begin
      b = rmq_pkg::BR_Z;
      t = 22'(rmq_pkg::ONE) + 22'(m22) + 22'(m22) - 22'(tr);
    end
    case (b)
      rmq_pkg::BR_W: begin
        num[0] = da; num[1] = db; num[2] = dc;
      end
      rmq_pkg::BR_X: begin
        num[0] = da; num[1] = sa; num[2] = sb;
      end
      rmq_pkg::BR_Y: begin
        num[0] = db; num[1] = sa; num[2] = sc;
      end
      default: begin
        num[0] = dc; num[1] = sb; num[2] = sc;
      end
    endcase
    rad_next = (t <= 22'sd0) ? '0 : {t[18:0], 16'b0};
    side_next.br = b;
    for (int j = 0; j < 3; j++) begin
      side_next.neg[j] = num[j][MW-1];
      side_next.mag[j] = num[j][MW-1] ? MW'(-num[j]) : MW'(num[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      dec_valid <= in_valid;
      out_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dec_rad  <= rad_next;
      dec_side <= side_next;
      qw       <= q_next[0];
      qx       <= q_next[1];
      qy       <= q_next[2];
      qz       <= q_next[3];
    end
  end

  rmq_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .a_valid (dec_valid),
    .rad     (dec_rad),
    .a_side  (dec_side),
    .b_valid (sq_valid),
    .root    (sq_root),
    .b_side  (sq_side)
  );

  rmq_div u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .a_valid (sq_valid),
    .r       (sq_root),
    .a_side  (sq_side),
    .b_valid (dv_valid),
    .br      (dv_br),
    .diag    (dv_diag),
    .lane    (dv_lane)
  );

  // diagonal term at the branch position, the three lanes fill the rest
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (2'(k) == dv_br) begin
        q_next[k] = dv_diag;
      end else if (2'(k) < dv_br) begin
        q_next[k] = dv_lane[k];
      end else begin
        q_next[k] = dv_lane[(k == 0) ? 0 : k-1];
      end
    end
  end

  `RMQ_ASSERT_NOW(a_hold_blocks_input, out_valid && out_stall, in_stall)
  `RMQ_ASSERT_NEXT(a_out_follows_pipe, !in_stall, out_valid == $past(dv_valid))
  `RMQ_ASSERT_NOW(a_out_range, out_valid, qw <= 18'sd65536 && qw >= -18'sd65536 && qx <= 18'sd65536 && qx >= -18'sd65536 && qy <= 18'sd65536 && qy >= -18'sd65536 && qz <= 18'sd65536 && qz >= -18'sd65536)

endmodule

`default_nettype wire

@@ hw/rtl/rmq_sqrt.sv @@
// ----------------------------------------------------------------------------
// rmq_sqrt
// pipelined integer square root, one result bit per register stage
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_sqrt (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      en,
  input  wire logic                      a_valid,
  input  wire logic [rmq_pkg::RADW-1:0]  rad,
  input  wire rmq_pkg::side_t            a_side,
  output logic                           b_valid,
  output logic [rmq_pkg::FW-1:0]         root,
  output rmq_pkg::side_t                 b_side
);

  localparam int N  = rmq_pkg::SQ_STEPS;
  localparam int NW = 2 * N;
  localparam int RW = rmq_pkg::FW + 4;

  logic [N-1:0]          v;
  logic [NW-1:0]         nsh [N];
  logic [RW-1:0]         rem [N];
  logic [rmq_pkg::FW-1:0] rt [N];
  rmq_pkg::side_t        sd [N];

  logic [NW-1:0]          nsh_next [N];
  logic [RW-1:0]          rem_next [N];
  logic [rmq_pkg::FW-1:0] rt_next [N];

  always_comb begin
    logic [NW-1:0]          sn;
    logic [RW-1:0]          sr;
    logic [rmq_pkg::FW-1:0] so;
    logic [RW-1:0]          rsh;
    logic [RW-1:0]          trial;
    for (int s = 0; s < N; s++) begin
      if (s == 0) begin
        sn = NW'(rad);
        sr = '0;
        so = '0;
      end else begin
        sn = nsh[s-1];
        sr = rem[s-1];
        so = rt[s-1];
      end
      rsh   = {sr[RW-3:0], sn[NW-1:NW-2]};
      trial = RW'({so, 2'b01});
      if (rsh >= trial) begin
        rem_next[s] = rsh - trial;
        rt_next[s]  = {so[rmq_pkg::FW-2:0], 1'b1};
      end else begin
        rem_next[s] = rsh;
        rt_next[s]  = {so[rmq_pkg::FW-2:0], 1'b0};
      end
      nsh_next[s] = {sn[NW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[N-2:0], a_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < N; s++) begin
        nsh[s] <= nsh_next[s];
        rem[s] <= rem_next[s];
        rt[s]  <= rt_next[s];
        sd[s]  <= (s == 0) ? a_side : sd[(s == 0) ? 0 : s-1];
      end
    end
  end

  assign b_valid = v[N-1];
  assign root    = rt[N-1];
  assign b_side  = sd[N-1];

endmodule

`default_nettype wire

@@ hw/rtl/rmq_div.sv @@
// ----------------------------------------------------------------------------
// rmq_div
// three pipelined restoring dividers for the off-diagonal terms, with
// rounding, saturation and the diagonal term
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          a_valid,
  input  wire logic [rmq_pkg::FW-1:0]        r,
  input  wire rmq_pkg::side_t                a_side,
  output logic                               b_valid,
  output rmq_pkg::br_t                       br,
  output logic [rmq_pkg::FW-1:0]             diag,
  output logic [2:0][rmq_pkg::FW-1:0]        lane
);

  localparam int S  = rmq_pkg::DIV_STEPS + 1;
  localparam int PW = rmq_pkg::PW;
  localparam int QW = rmq_pkg::DIV_STEPS;

  logic [S-1:0]           v;
  logic [rmq_pkg::FW-1:0] rr [S];
  rmq_pkg::side_t         sd [S];
  logic [2:0][PW-1:0]     p [S];
  logic [2:0][QW-1:0]     q [S];
  logic [2:0]             sat [S];

  logic [2:0][PW-1:0]     p_next [S];
  logic [2:0][QW-1:0]     q_next [S];
  logic [2:0]             sat_next;

  // prep: rounded dividend and overflow against 65537 * r
  // then one quotient bit per stage
  always_comb begin
    logic [PW-1:0] lim;
    logic [PW-1:0] sub;
    lim = PW'({r, 16'b0}) + PW'(r);
    for (int j = 0; j < 3; j++) begin
      p_next[0][j] = PW'({a_side.mag[j], 15'b0}) + PW'(r >> 1);
      q_next[0][j] = '0;
      sat_next[j]  = (p_next[0][j] >= lim) || (r == '0);
    end
    for (int s = 1; s < S; s++) begin
      sub = PW'(rr[s-1]) << (S - 1 - s);
      for (int j = 0; j < 3; j++) begin
        p_next[s][j] = p[s-1][j];
        q_next[s][j] = q[s-1][j];
        if (p[s-1][j] >= sub) begin
          p_next[s][j]          = p[s-1][j] - sub;
          q_next[s][j][S-1-s]   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[S-2:0], a_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rr[0]  <= r;
      sd[0]  <= a_side;
      sat[0] <= sat_next;
      p[0]   <= p_next[0];
      q[0]   <= q_next[0];
      for (int s = 1; s < S; s++) begin
        rr[s]  <= rr[s-1];
        sd[s]  <= sd[s-1];
        sat[s] <= sat[s-1];
        p[s]   <= p_next[s];
        q[s]   <= q_next[s];
      end
    end
  end

  always_comb begin
    logic [rmq_pkg::FW:0]   dh;
    logic [rmq_pkg::FW-1:0] mg;
    dh   = (({1'b0, rr[S-1]}) + (rmq_pkg::FW+1)'(1)) >> 1;
    diag = (dh > (rmq_pkg::FW+1)'(rmq_pkg::ONE)) ? rmq_pkg::FW'(rmq_pkg::ONE)
                                                 : dh[rmq_pkg::FW-1:0];
    for (int j = 0; j < 3; j++) begin
      if (rr[S-1] == '0) begin
        mg = '0;
      end else if (sat[S-1][j]) begin
        mg = rmq_pkg::FW'(rmq_pkg::ONE);
      end else begin
        mg = rmq_pkg::FW'(q[S-1][j]);
      end
      lane[j] = sd[S-1].neg[j] ? (~mg + rmq_pkg::FW'(1)) : mg;
    end
  end

  assign b_valid = v[S-1];
  assign br      = sd[S-1].br;

endmodule

`default_nettype wire
